// ----- hw/rtl/vertex_normal_accumulator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Shared property forms for the checker of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_NOW(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_NEXT(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Types, codes and fixed-point constants shared by the accumulator modules.
// ----------------------------------------------------------------------------
package vna_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_BITS_DEF   = 16;

	localparam int IDX_W    = 10;
	localparam int POS_W    = 16;
	localparam int NORM_W   = 16;
	localparam int STAT_W   = 2;
	localparam int VCOUNT_W = 11;
	localparam int SUM_W    = 24;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

	// Normalizer formats: magnitudes are brought below 2^MAG_W before squaring.
	localparam int MAG_W = 30;
	localparam int LEN_W = 31;
	localparam int QUO_W = 15;
	localparam int DIV_W = 48;
	localparam int RT_W  = 64;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FACE  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} vna_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ZERO  = 2'd2
	} vna_status_t;

	typedef struct packed {
		vna_op_t                 op;
		logic [IDX_W-1:0]        index_a;
		logic [IDX_W-1:0]        index_b;
		logic [IDX_W-1:0]        index_c;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} vna_item_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
		logic [STAT_W-1:0]        status;
	} vna_result_t;

	typedef struct packed {
		logic rd;
		logic clr;
		logic add;
	} vna_sum_cmd_t;

endpackage

// ----- hw/rtl/vna_sum_store.sv -----
// ----------------------------------------------------------------------------
// Normal sum store
// Accumulator memory with registered reads and a saturating write-back add.
// ----------------------------------------------------------------------------
module vna_sum_store #(
	parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
	input  logic                                   clk,
	input  vna_pkg::vna_sum_cmd_t                  cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0]        addr,
	input  logic [2:0][vna_pkg::NORM_W-1:0]        delta,
	output logic [2:0][vna_pkg::SUM_W-1:0]         rd_data
);
	import vna_pkg::*;

	logic [3*SUM_W-1:0]    mem [MAX_VERTICES];
	logic [2:0][SUM_W-1:0] rd_q;
	logic [2:0][SUM_W-1:0] sat_sum;
	logic [SUM_W:0]        wide [3];

	// An add always follows a read of the same entry, so rd_q holds the old sum.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = {rd_q[i][SUM_W-1], rd_q[i]} +
				{{(SUM_W+1-NORM_W){delta[i][NORM_W-1]}}, delta[i]};
			if (wide[i][SUM_W] != wide[i][SUM_W-1]) begin
				sat_sum[i] = wide[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
					: {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sat_sum[i] = wide[i][SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[addr];
		end
		if (cmd.clr) begin
			mem[addr] <= '0;
		end else if (cmd.add) begin
			mem[addr] <= sat_sum;
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- hw/rtl/vna_normalize.sv -----
// ----------------------------------------------------------------------------
// Unit vector normalizer
// Scales a signed vector to Q1.14 with a bit-serial root and divider.
// ----------------------------------------------------------------------------
module vna_normalize #(
	parameter int VEC_W = 35
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [2:0][VEC_W-1:0]             vec,
	output logic                              done,
	output logic                              zero,
	output logic [2:0][vna_pkg::NORM_W-1:0]   norm
);
	import vna_pkg::*;

	localparam int MW    = (VEC_W > MAG_W) ? VEC_W : MAG_W;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SS_W  = SQ_W + 2;
	localparam int DEN_W = LEN_W + 1;

	typedef enum logic [5:0] {
		N_IDLE  = 6'b000001,
		N_SHIFT = 6'b000010,
		N_SQ    = 6'b000100,
		N_ROOT  = 6'b001000,
		N_DSET  = 6'b010000,
		N_DIV   = 6'b100000
	} nstate_t;

	nstate_t               state_q;
	logic [2:0][MW-1:0]    mag_q;
	logic [2:0]            neg_q;
	logic [1:0]            k_q;
	logic [SQ_W-1:0]       sq_q;
	logic [SS_W-1:0]       ss_q;
	logic [SS_W-1:0]       ss_next;
	logic [MAG_W-1:0]      mag_sel;
	logic [SS_W-1:0]       v_q;
	logic [RT_W-1:0]       r_q;
	logic [RT_W-1:0]       bit_q;
	logic [4:0]            rk_q;
	logic [RT_W:0]         trial;
	logic                  root_ge;
	logic [DEN_W-1:0]      den;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      den_sh;
	logic                  div_ge;
	logic [3:0]            qb_q;
	logic [QUO_W-1:0]      q_q;
	logic [QUO_W-1:0]      q_next;
	logic [NORM_W-1:0]     q_ext;
	logic [1:0]            dk_q;
	logic                  big;
	logic                  done_q;
	logic                  zero_q;
	logic [2:0][NORM_W-1:0] norm_q;

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			big = big | ((mag_q[i] >> MAG_W) != '0);
		end
		case (k_q)
			2'd0:    mag_sel = mag_q[0][MAG_W-1:0];
			2'd1:    mag_sel = mag_q[1][MAG_W-1:0];
			default: mag_sel = mag_q[2][MAG_W-1:0];
		endcase
		ss_next = ss_q + SS_W'(sq_q);
		trial   = {1'b0, r_q} + {1'b0, bit_q};
		root_ge = (RT_W+1)'(v_q) >= trial;
		den     = {r_q[LEN_W-1:0], 1'b0};
		den_sh  = DIV_W'(den) << qb_q;
		div_ge  = rem_q >= den_sh;
		q_next  = q_q;
		q_next[qb_q] = div_ge;
		q_ext   = NORM_W'(q_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						for (int i = 0; i < 3; i++) begin
							neg_q[i] <= vec[i][VEC_W-1];
							mag_q[i] <= MW'(vec[i][VEC_W-1] ? (~vec[i] + 1'b1) : vec[i]);
						end
						state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (big) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_q[i] >> 1;
						end
					end else begin
						k_q     <= '0;
						ss_q    <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					// One square a cycle; the previous square is summed meanwhile.
					if (k_q != 2'd3) begin
						sq_q <= mag_sel * mag_sel;
					end
					if (k_q != 2'd0) begin
						ss_q <= ss_next;
					end
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						if (ss_next == '0) begin
							zero_q  <= 1'b1;
							norm_q  <= '0;
							done_q  <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							v_q     <= ss_next;
							r_q     <= '0;
							bit_q   <= RT_W'(1) << (RT_W - 2);
							rk_q    <= '0;
							state_q <= N_ROOT;
						end
					end
				end
				N_ROOT: begin
					if (root_ge) begin
						v_q <= SS_W'((RT_W+1)'(v_q) - trial);
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					rk_q  <= rk_q + 1'b1;
					if (rk_q == 5'd31) begin
						dk_q    <= '0;
						state_q <= N_DSET;
					end
				end
				N_DSET: begin
					// Rounded quotient: (mag * 2^15 + L) / (2L).
					rem_q   <= (DIV_W'(mag_q[dk_q][MAG_W-1:0]) << QUO_W) +
						DIV_W'(r_q[LEN_W-1:0]);
					q_q     <= '0;
					qb_q    <= 4'(QUO_W - 1);
					state_q <= N_DIV;
				end
				N_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - den_sh;
					end
					q_q  <= q_next;
					qb_q <= qb_q - 1'b1;
					if (qb_q == '0) begin
						norm_q[dk_q] <= neg_q[dk_q] ? (~q_ext + 1'b1) : q_ext;
						dk_q <= dk_q + 1'b1;
						if (dk_q == 2'd2) begin
							zero_q  <= 1'b0;
							done_q  <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							state_q <= N_DSET;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign zero = zero_q;
	assign norm = norm_q;

endmodule

// ----- hw/rtl/vertex_normal_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Position store, face normal generation and per-vertex normal accumulation.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the in channel (in_valid, in_stall, in_item) and each
// produces exactly one result on the res channel (res_valid, res_stall,
// res_item). The cfg channel writes the vertex count, which the user must do
// only while the block is idle; the block itself does not enforce it. One
// command is processed at a time; a new one is taken as soon as the previous
// result sits in the output register, even if it is not yet taken. The
// bit-serial square root (32 steps) and divider set the add-face and read
// time. After reset the accumulator memory is swept to zero, one entry a
// cycle, with in_stall high. Vertex positions are not cleared.
// When res_stall is high the result holds and a finished command waits for
// the output register, keeping in_stall high.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit #(
	parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  vna_pkg::vna_item_t            in_item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output vna_pkg::vna_result_t          res_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vna_pkg::VCOUNT_W-1:0]  cfg_data
);
	import vna_pkg::*;

	localparam int AW     = $clog2(MAX_VERTICES);
	localparam int CNT_W  = ($clog2(MAX_VERTICES + 1) > VCOUNT_W) ?
		$clog2(MAX_VERTICES + 1) : VCOUNT_W;
	localparam int CW     = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
	localparam int EW     = CW + 1;
	localparam int PW     = 2 * EW;
	localparam int VEC_W  = (PW + 1 > SUM_W + 1) ? PW + 1 : SUM_W + 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

	typedef enum logic [12:0] {
		S_INIT   = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_DECODE = 13'b0000000000100,
		S_PRD    = 13'b0000000001000,
		S_EDGE   = 13'b0000000010000,
		S_CROSS  = 13'b0000000100000,
		S_NWAIT  = 13'b0000001000000,
		S_ACCRD  = 13'b0000010000000,
		S_ACCWR  = 13'b0000100000000,
		S_VRD    = 13'b0001000000000,
		S_CLR    = 13'b0010000000000,
		S_OUT    = 13'b0100000000000,
		S_SPARE  = 13'b1000000000000
	} state_t;

	state_t                      state_q;
	vna_item_t                   item_q;
	logic [VCOUNT_W-1:0]         vcount_q;
	logic [CNT_W-1:0]            cnt;
	logic [CNT_W-1:0]            ia_ext, ib_ext, ic_ext;
	logic                        a_ok, face_ok;
	logic [AW-1:0]               addr_a, addr_b, addr_c;

	logic [3*CW-1:0]             pos_mem [MAX_VERTICES];
	logic [3*CW-1:0]             pos_rd_q;
	logic                        pos_rd_en;
	logic [AW-1:0]               pos_rd_addr;
	logic                        pos_wr_en;

	logic [1:0]                  pk_q;
	logic [3*CW-1:0]             corner_q [3];
	logic signed [EW-1:0]        e1_q [3];
	logic signed [EW-1:0]        e2_q [3];
	logic [2:0]                  ck_q;
	logic [2:0]                  tag;
	logic signed [EW-1:0]        mul_a, mul_b;
	logic signed [PW-1:0]        prod_q;
	logic [2:0][VEC_W-1:0]       vec_q;

	logic                        norm_start_q;
	logic                        norm_done;
	logic                        norm_zero;
	logic [2:0][NORM_W-1:0]      norm_res;

	vna_sum_cmd_t                sum_cmd;
	logic [AW-1:0]               sum_addr;
	logic [2:0][SUM_W-1:0]       sum_rd;
	logic [1:0]                  acc_j_q;
	logic [AW-1:0]               acc_addr;
	logic [CNT_W-1:0]            clr_q;
	logic [CNT_W-1:0]            clr_lim_q;

	logic [2:0][NORM_W-1:0]      pend_n_q;
	vna_status_t                 pend_st_q;
	logic                        res_valid_q;
	vna_result_t                 res_item_q;
	logic                        out_free;

	// Index range checks against the vertex count in effect.
	always_comb begin
		cnt     = (CNT_W'(vcount_q) > MAX_CNT) ? MAX_CNT : CNT_W'(vcount_q);
		ia_ext  = CNT_W'(item_q.index_a);
		ib_ext  = CNT_W'(item_q.index_b);
		ic_ext  = CNT_W'(item_q.index_c);
		a_ok    = ia_ext < cnt;
		face_ok = a_ok && (ib_ext < cnt) && (ic_ext < cnt);
		addr_a  = ia_ext[AW-1:0];
		addr_b  = ib_ext[AW-1:0];
		addr_c  = ic_ext[AW-1:0];
		case (acc_j_q)
			2'd0:    acc_addr = addr_a;
			2'd1:    acc_addr = addr_b;
			default: acc_addr = addr_c;
		endcase
	end

	// Memory port control.
	always_comb begin
		pos_rd_en   = 1'b0;
		pos_rd_addr = addr_a;
		pos_wr_en   = 1'b0;
		sum_cmd     = '0;
		sum_addr    = addr_a;
		case (state_q)
			S_DECODE: begin
				case (item_q.op)
					OP_WRITE: pos_wr_en = a_ok;
					OP_FACE:  pos_rd_en = face_ok;
					OP_READ:  sum_cmd.rd = a_ok;
					default:  pos_rd_en = 1'b0;
				endcase
			end
			S_PRD: begin
				pos_rd_en   = (pk_q != 2'd2);
				pos_rd_addr = (pk_q == 2'd0) ? addr_b : addr_c;
			end
			S_INIT, S_CLR: begin
				sum_cmd.clr = (clr_q < clr_lim_q);
				sum_addr    = clr_q[AW-1:0];
			end
			S_ACCRD: begin
				sum_cmd.rd = 1'b1;
				sum_addr   = acc_addr;
			end
			S_ACCWR: begin
				sum_cmd.add = 1'b1;
				sum_addr    = acc_addr;
			end
			default: sum_cmd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_wr_en) begin
			pos_mem[addr_a] <= {item_q.pos_z[CW-1:0], item_q.pos_y[CW-1:0],
				item_q.pos_x[CW-1:0]};
		end
		if (pos_rd_en) begin
			pos_rd_q <= pos_mem[pos_rd_addr];
		end
	end

	// Cross product (B-A) x (C-A) on one multiplier, two products per component.
	always_comb begin
		tag = ck_q - 1'b1;
		case (ck_q)
			3'd0: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			3'd5: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			vcount_q     <= VCOUNT_RESET;
			clr_q        <= '0;
			clr_lim_q    <= MAX_CNT;
			norm_start_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			norm_start_q <= 1'b0;
			if (cfg_valid) begin
				vcount_q <= cfg_data;
			end
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (clr_q < clr_lim_q) begin
						clr_q <= clr_q + 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					pend_n_q <= '0;
					pk_q     <= '0;
					case (item_q.op)
						OP_WRITE: begin
							pend_st_q <= a_ok ? ST_OK : ST_RANGE;
							state_q   <= S_OUT;
						end
						OP_FACE: begin
							pend_st_q <= face_ok ? ST_OK : ST_RANGE;
							state_q   <= face_ok ? S_PRD : S_OUT;
						end
						OP_READ: begin
							pend_st_q <= a_ok ? ST_OK : ST_RANGE;
							state_q   <= a_ok ? S_VRD : S_OUT;
						end
						default: begin
							pend_st_q <= ST_OK;
							clr_q     <= '0;
							clr_lim_q <= cnt;
							state_q   <= S_CLR;
						end
					endcase
				end
				S_PRD: begin
					corner_q[pk_q] <= pos_rd_q;
					pk_q <= pk_q + 1'b1;
					if (pk_q == 2'd2) begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= $signed({corner_q[1][i*CW+CW-1], corner_q[1][i*CW +: CW]}) -
							$signed({corner_q[0][i*CW+CW-1], corner_q[0][i*CW +: CW]});
						e2_q[i] <= $signed({corner_q[2][i*CW+CW-1], corner_q[2][i*CW +: CW]}) -
							$signed({corner_q[0][i*CW+CW-1], corner_q[0][i*CW +: CW]});
					end
					vec_q   <= '0;
					ck_q    <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					prod_q <= mul_a * mul_b;
					if (ck_q != 3'd0) begin
						if (tag[0]) begin
							vec_q[tag[2:1]] <= vec_q[tag[2:1]] - VEC_W'(prod_q);
						end else begin
							vec_q[tag[2:1]] <= vec_q[tag[2:1]] + VEC_W'(prod_q);
						end
					end
					ck_q <= ck_q + 1'b1;
					if (ck_q == 3'd6) begin
						norm_start_q <= 1'b1;
						state_q      <= S_NWAIT;
					end
				end
				S_VRD: begin
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= VEC_W'($signed(sum_rd[i]));
					end
					norm_start_q <= 1'b1;
					state_q      <= S_NWAIT;
				end
				S_NWAIT: begin
					if (norm_done) begin
						acc_j_q <= '0;
						if (norm_zero) begin
							pend_st_q <= ST_ZERO;
							state_q   <= S_OUT;
						end else begin
							pend_n_q <= norm_res;
							state_q  <= (item_q.op == OP_FACE) ? S_ACCRD : S_OUT;
						end
					end
				end
				S_ACCRD: begin
					state_q <= S_ACCWR;
				end
				S_ACCWR: begin
					acc_j_q <= acc_j_q + 1'b1;
					state_q <= (acc_j_q == 2'd2) ? S_OUT : S_ACCRD;
				end
				S_CLR: begin
					if (clr_q < clr_lim_q) begin
						clr_q <= clr_q + 1'b1;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						res_item_q.norm_x <= pend_n_q[0];
						res_item_q.norm_y <= pend_n_q[1];
						res_item_q.norm_z <= pend_n_q[2];
						res_item_q.status <= pend_st_q;
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	vna_sum_store #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_sum_store (
		.clk     (clk),
		.cmd     (sum_cmd),
		.addr    (sum_addr),
		.delta   (pend_n_q),
		.rd_data (sum_rd)
	);

	vna_normalize #(
		.VEC_W(VEC_W)
	) u_normalize (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start_q),
		.vec    (vec_q),
		.done   (norm_done),
		.zero   (norm_zero),
		.norm   (norm_res)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;
	assign cfg_ready = 1'b1;

endmodule

// ----- hw/rtl/vna_checker.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_unit_assert.svh"

module vna_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_stall,
	input vna_pkg::vna_result_t res_item
);
	import vna_pkg::*;

	localparam logic signed [NORM_W-1:0] UNIT_POS = NORM_W'(16384);
	localparam logic signed [NORM_W-1:0] UNIT_NEG = -NORM_W'(16384);

	logic in_bounds;
	logic zero_norm;
	logic bad_status;

	always_comb begin
		in_bounds = (res_item.norm_x <= UNIT_POS) && (res_item.norm_x >= UNIT_NEG) &&
			(res_item.norm_y <= UNIT_POS) && (res_item.norm_y >= UNIT_NEG) &&
			(res_item.norm_z <= UNIT_POS) && (res_item.norm_z >= UNIT_NEG);
		zero_norm  = (res_item.norm_x == '0) && (res_item.norm_y == '0) &&
			(res_item.norm_z == '0);
		bad_status = (res_item.status != ST_OK);
	end

	`VNA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid, "result dropped while stalled")
	`VNA_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && res_stall, $stable(res_item), "stalled result changed")
	`VNA_ASSERT_NOW(a_fail_zero, clk, arst_n, res_valid && bad_status, zero_norm, "failed command returned a nonzero normal")
	`VNA_ASSERT_NOW(a_unit_range, clk, arst_n, res_valid, in_bounds, "normal component beyond unit length")

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (.*);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives write, add-face, read and clear commands through the block under
// random idling and a long output hold-off, predicts every result in place,
// and compares each result field by field in the order the results arrive.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import vna_pkg::*;

	localparam int NVERT = 1024;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	vna_item_t in_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	vna_result_t res_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [VCOUNT_W-1:0] cfg_data = '0;

	always #2 clk = ~clk;

	vertex_normal_accumulator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic signed [15:0] pos_store [NVERT][3];
	bit written [NVERT];
	int sum_store [NVERT][3];
	int unsigned vcount_now;

	vna_result_t expected_results [$];
	int errors = 0;
	int n_results = 0;
	int n_items = 0;
	int idle_cycles = 0;
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	bit hold_output = 1'b0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Scales a vector to Q1.14 unit length; returns the status.
	function automatic vna_status_t unit_normal(input longint v [3], output int n [3]);
		longint unsigned mag [3];
		longint unsigned mx, acc, len, q;
		bit neg [3];
		mx = 0;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? longint'(-v[i]) : v[i];
			if (mag[i] > mx) mx = mag[i];
		end
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
			mx >>= 1;
		end
		for (int i = 0; i < 3; i++) acc += mag[i] * mag[i];
		for (int i = 0; i < 3; i++) n[i] = 0;
		if (acc == 0) return ST_ZERO;
		len = int_sqrt(acc);
		for (int i = 0; i < 3; i++) begin
			q = (2 * mag[i] * 16384 + len) / (2 * len);
			n[i] = neg[i] ? -int'(q) : int'(q);
		end
		return ST_OK;
	endfunction

	function automatic vna_result_t predict_normal(vna_item_t it);
		vna_result_t r;
		int n [3];
		longint e1 [3], e2 [3], c [3];
		longint s;
		int unsigned cnt;
		vna_status_t st;
		cnt = (vcount_now > NVERT) ? NVERT : vcount_now;
		n = '{0, 0, 0};
		st = ST_OK;
		case (it.op)
			OP_WRITE: begin
				if (it.index_a >= cnt) st = ST_RANGE;
				else begin
					pos_store[it.index_a] = '{it.pos_x, it.pos_y, it.pos_z};
					written[it.index_a] = 1'b1;
				end
			end
			OP_FACE: begin
				if (it.index_a >= cnt || it.index_b >= cnt || it.index_c >= cnt) st = ST_RANGE;
				else begin
					for (int i = 0; i < 3; i++) begin
						e1[i] = longint'(pos_store[it.index_b][i]) - pos_store[it.index_a][i];
						e2[i] = longint'(pos_store[it.index_c][i]) - pos_store[it.index_a][i];
					end
					c[0] = e1[1] * e2[2] - e1[2] * e2[1];
					c[1] = e1[2] * e2[0] - e1[0] * e2[2];
					c[2] = e1[0] * e2[1] - e1[1] * e2[0];
					st = unit_normal(c, n);
					if (st == ST_OK)
						for (int i = 0; i < 3; i++)
							foreach (c[k]) begin
								int idx;
								idx = (k == 0) ? it.index_a : (k == 1) ? it.index_b : it.index_c;
								s = longint'(sum_store[idx][i]) + n[i];
								if (s > 8388607) s = 8388607;
								if (s < -8388608) s = -8388608;
								sum_store[idx][i] = int'(s);
							end
				end
			end
			OP_READ: begin
				if (it.index_a >= cnt) st = ST_RANGE;
				else begin
					for (int i = 0; i < 3; i++) c[i] = sum_store[it.index_a][i];
					st = unit_normal(c, n);
				end
			end
			default: begin
				for (int k = 0; k < cnt; k++) sum_store[k] = '{0, 0, 0};
			end
		endcase
		r.norm_x = n[0][15:0];
		r.norm_y = n[1][15:0];
		r.norm_z = n[2][15:0];
		r.status = st;
		return r;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, res_item);
			end else begin
				vna_result_t e;
				e = expected_results.pop_front();
				if (res_item.norm_x !== e.norm_x) begin
					errors++;
					$display("%0t: norm_x expected %0d actual %0d", $time, e.norm_x,
						res_item.norm_x);
				end
				if (res_item.norm_y !== e.norm_y) begin
					errors++;
					$display("%0t: norm_y expected %0d actual %0d", $time, e.norm_y,
						res_item.norm_y);
				end
				if (res_item.norm_z !== e.norm_z) begin
					errors++;
					$display("%0t: norm_z expected %0d actual %0d", $time, e.norm_z,
						res_item.norm_z);
				end
				if (res_item.status !== e.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, e.status,
						res_item.status);
				end
			end
		end
	end

	// Receiver stall: random bursts, or a long hold-off when asked.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_output) begin
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_output = 1'b0;
				res_stall <= 1'b0;
			end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 17);
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_results.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Valid stays high after a transfer until the next item replaces the
	// payload or the sender goes idle.
	task automatic send_command(vna_item_t it);
		int n;
		if (send_gaps && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_normal(it));
		n_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_vertex_count(int unsigned v);
		wait_drained();
		cfg_data <= v[VCOUNT_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vcount_now = v[VCOUNT_W-1:0];
	endtask

	function automatic vna_item_t make_cmd(vna_op_t op, int a, int b, int c,
			int x, int y, int z);
		vna_item_t it;
		it.op = op;
		it.index_a = a[9:0];
		it.index_b = b[9:0];
		it.index_c = c[9:0];
		it.pos_x = x[15:0];
		it.pos_y = y[15:0];
		it.pos_z = z[15:0];
		return it;
	endfunction

	// Picks a written vertex below lim, or writes one first.
	task automatic pick_vertex(int lim, output int idx);
		idx = $urandom_range(0, lim - 1);
		if (!written[idx])
			send_command(make_cmd(OP_WRITE, idx, $urandom, $urandom, $urandom, $urandom,
				$urandom));
	endtask

	task automatic test_directed();
		send_command(make_cmd(OP_READ, 5, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_WRITE, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_WRITE, 1, 0, 0, 256, 0, 0));
		send_command(make_cmd(OP_WRITE, 2, 0, 0, 0, 256, 0));
		send_command(make_cmd(OP_WRITE, 3, 1023, 1023, 32767, -32768, 32767));
		send_command(make_cmd(OP_WRITE, 1023, 0, 0, -32768, 32767, -32768));
		send_command(make_cmd(OP_WRITE, 4, 0, 0, -1, -1, -1));
		send_command(make_cmd(OP_FACE, 0, 1, 2, 0, 0, 0));
		send_command(make_cmd(OP_FACE, 0, 2, 1, 0, 0, 0));
		send_command(make_cmd(OP_FACE, 0, 3, 1023, 0, 0, 0));
		send_command(make_cmd(OP_FACE, 0, 0, 1, 0, 0, 0));
		send_command(make_cmd(OP_FACE, 3, 1023, 4, 0, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_READ, 1023, 0, 0, 0, 0, 0));
		// Repeated faces drive the sums toward saturation.
		repeat (6) send_command(make_cmd(OP_FACE, 0, 1, 2, 0, 0, 0));
		send_command(make_cmd(OP_READ, 2, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_saturation();
		// A sum of 2^23 needs 512 unit faces on one vertex.
		send_gaps = 1'b0;
		repeat (520) send_command(make_cmd(OP_FACE, 0, 1, 2, 0, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
		send_gaps = 1'b1;
	endtask

	task automatic test_vertex_counts();
		write_vertex_count(3);
		send_command(make_cmd(OP_FACE, 0, 1, 3, 0, 0, 0));
		send_command(make_cmd(OP_WRITE, 3, 0, 0, 1, 1, 1));
		send_command(make_cmd(OP_FACE, 2, 1, 0, 0, 0, 0));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_READ, 1023, 0, 0, 0, 0, 0));
		write_vertex_count(0);
		send_command(make_cmd(OP_WRITE, 0, 0, 0, 5, 5, 5));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_READ, 1023, 0, 0, 0, 0, 0));
		write_vertex_count(2047);
		send_command(make_cmd(OP_READ, 1023, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0));
	endtask

	task automatic run_random(int count, int lim);
		int a, b, c, r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// Corners over the whole index range; those in use are written first.
				pick_vertex(1024, a);
				pick_vertex(1024, b);
				pick_vertex(1024, c);
				send_command(make_cmd(OP_FACE, a, b, c, 0, 0, 0));
			end else if (r < 30) begin
				send_command(make_cmd(OP_WRITE, $urandom_range(0, 1023), $urandom, $urandom,
					$urandom, $urandom, $urandom));
			end else if (r < 75) begin
				pick_vertex(lim, a);
				pick_vertex(lim, b);
				pick_vertex(lim, c);
				send_command(make_cmd(OP_FACE, a, b, c, 0, 0, 0));
			end else if (r < 97) begin
				send_command(make_cmd(OP_READ, $urandom_range(0, lim - 1), $urandom, $urandom,
					$urandom, $urandom, $urandom));
			end else begin
				send_command(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, 0, 0, 0));
			end
		end
	endtask

	task automatic test_random();
		write_vertex_count(1024);
		run_random(40, 12);
		write_vertex_count(40);
		run_random(30, 50);
		write_vertex_count(1023);
		run_random(30, 1024);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_output = 1'b1;
		send_gaps = 1'b0;
		run_random(20, 12);
		send_gaps = 1'b1;
	endtask

	task automatic test_no_gaps();
		wait_drained();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		run_random(30, 16);
	endtask

	initial begin
		for (int k = 0; k < NVERT; k++) begin
			written[k] = 1'b0;
			sum_store[k] = '{0, 0, 0};
		end
		vcount_now = 1024;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_saturation();
		test_vertex_counts();
		test_random();
		test_backpressure();
		test_no_gaps();
		wait_drained();
		$display("Sent %0d commands and checked %0d results, over vertex counts 0 to 2047,",
			n_items, n_results);
		$display("with random idling, a long output hold-off and accumulator saturation.");
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
